// ----- rtl/gpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared types and constants for the lattice path counter.
// ----------------------------------------------------------------------------
package gpc_pkg;

  localparam int MAX_DIM_DEF = 15;   // default largest grid dimension
  localparam int DIM_IN_W    = 4;    // width of the rows and cols fields
  localparam int WP_W        = 8;    // width of the waypoint field
  localparam int CNT_W       = 26;   // width of the path count
  localparam int STEP_W      = $clog2(WP_W);
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHK,
    S_WALK,
    S_RES
  } state_t;

  // sequencer -> datapath
  typedef struct packed {
    logic load;   // item taken this cycle
    logic div;    // one restoring divide step
    logic chk;    // range check, latch waypoint position
    logic walk;   // one grid cell of the recurrence
    logic res;    // move the count to the output register
  } ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic skip;        // no walk needed (bad waypoint or empty grid)
    logic walk_last;   // current cell is the bottom-right one
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

// ----- rtl/gpc_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpc_alu
// Shared adder/subtractor: used for divide steps and for the cell sums.
// ----------------------------------------------------------------------------
module gpc_alu
  import gpc_pkg::*;
(
  input  logic [CNT_W-1:0] a,
  input  logic [CNT_W-1:0] b,
  input  logic             sub,   // 1: a - b, carry out means a >= b
  output logic [CNT_W:0]   sum
);

  logic [CNT_W-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign sum  = {1'b0, a} + {1'b0, b_op} + {{CNT_W{1'b0}}, sub};

endmodule

// ----- rtl/gpc_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpc_seq
// Sequencer: divide steps, range check, grid walk, result handoff.
// ----------------------------------------------------------------------------
module gpc_seq
  import gpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (in_valid) state_nxt = S_DIV;
      end
      S_DIV: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(WP_W - 1)) state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = sts.skip ? S_RES : S_WALK;
      end
      S_WALK: begin
        if (sts.walk_last) state_nxt = S_RES;
      end
      S_RES: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs; hold the input off while reset is applied
  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        ctl.load = in_valid && rst_n;
      end
      S_DIV:  ctl.div  = 1'b1;
      S_CHK:  ctl.chk  = 1'b1;
      S_WALK: ctl.walk = 1'b1;
      S_RES:  ctl.res  = sts.out_free;
      default: ctl = '0;
    endcase
  end

endmodule

// ----- rtl/grid_path_count_via_waypoint.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_path_count_via_waypoint
// Counts monotone right/down lattice paths through an optional waypoint.
// ----------------------------------------------------------------------------
//
//   channel | dir | tdata                              | tuser
//   --------+-----+------------------------------------+--------------
//   in_     | in  | rows[3:0] cols[7:4] waypoint[15:8] | -
//   out_    | out | path_count[25:0], zero pad         | bad_waypoint
//
// An item is accepted, then goes through 8 restoring divide steps and one
// range check, walks the grid one cell per cycle through the shared adder,
// and ends with the handoff. Empty grids and bad waypoints skip the walk.
// rst_n is synchronous and active low; it idles the sequencer and empties
// the output register. The next item is taken while a result still waits;
// a stalled result holds the sequencer in its handoff cycle.
//
// The walk runs the recurrence cell(i,j) = cell(i-1,j) + cell(i,j-1) in
// row-major order with one row buffer. Cells that cannot lie on a path
// through the waypoint (neither both coordinates at or before it nor both
// at or after it) are forced to zero, so the bottom-right cell ends up
// holding the number of paths through the waypoint. No waypoint acts as a
// waypoint on the top-left cell.
//
module grid_path_count_via_waypoint
  import gpc_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // rows[3:0], cols[7:4], waypoint[15:8]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // path_count[25:0], zeros[31:26]
  output logic                   out_tuser    // bad_waypoint
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);           // holds 0..MAX_DIM
  localparam int IDX_W = $clog2(MAX_DIM);               // holds 0..MAX_DIM-1
  localparam int EXT_W = (DIM_W > DIM_IN_W) ? DIM_W : DIM_IN_W;

  ctl_t ctl;
  sts_t sts;

  // input fields, saturated to MAX_DIM
  logic [DIM_IN_W-1:0] rows_in, cols_in;
  logic [WP_W-1:0]     wp_in;
  logic [EXT_W-1:0]    rows_ext, cols_ext, rows_sat, cols_sat;

  assign rows_in  = in_tdata[DIM_IN_W-1:0];
  assign cols_in  = in_tdata[2*DIM_IN_W-1:DIM_IN_W];
  assign wp_in    = in_tdata[2*DIM_IN_W+WP_W-1:2*DIM_IN_W];
  assign rows_ext = EXT_W'(rows_in);
  assign cols_ext = EXT_W'(cols_in);
  assign rows_sat = (rows_ext > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : rows_ext;
  assign cols_sat = (cols_ext > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : cols_ext;

  // item registers
  logic [DIM_W-1:0] rows_r, cols_r;
  logic             wzero_r;
  logic [WP_W-1:0]  quo_r;     // dividend, shifted out as quotient bits come in
  logic [DIM_W-1:0] rem_r;
  logic [IDX_W-1:0] wx_r, wy_r, i_r, j_r;
  logic [CNT_W-1:0] left_r, cnt_r;
  logic             bad_r;
  logic [CNT_W-1:0] row_r [MAX_DIM];

  // output register
  logic                   out_valid_r;
  logic [CNT_W-1:0]       out_cnt_r;
  logic                   out_bad_r;

  // shared unit operands
  logic [CNT_W-1:0] alu_a, alu_b;
  logic [CNT_W:0]   alu_sum;
  logic [DIM_W:0]   shifted;
  logic             ge;

  // walk helpers
  logic [DIM_W-1:0] rows_dec, cols_dec;
  logic [IDX_W-1:0] r_last, c_last;
  logic             dim_zero, bad_now;
  logic             in_mask;
  logic [CNT_W-1:0] above, cell_val;

  assign shifted  = {rem_r, quo_r[WP_W-1]};
  assign rows_dec = rows_r - DIM_W'(1);
  assign cols_dec = cols_r - DIM_W'(1);
  assign r_last   = rows_dec[IDX_W-1:0];
  assign c_last   = cols_dec[IDX_W-1:0];
  assign dim_zero = (rows_r == '0) || (cols_r == '0);
  assign bad_now  = !wzero_r && (dim_zero || (quo_r >= WP_W'(rows_r)));

  // the top-left cell seeds the walk with one
  always_comb begin
    if (i_r == '0) begin
      above = (j_r == '0) ? CNT_W'(1) : '0;
    end else begin
      above = row_r[j_r];
    end
  end

  // divide step: remainder trial minus cols; walk: above plus left
  assign alu_a = ctl.div ? CNT_W'(shifted) : above;
  assign alu_b = ctl.div ? CNT_W'(cols_r) : ((j_r == '0) ? '0 : left_r);
  assign ge    = alu_sum[CNT_W];

  gpc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (ctl.div),
    .sum (alu_sum)
  );

  assign in_mask  = ((i_r <= wx_r) && (j_r <= wy_r)) || ((i_r >= wx_r) && (j_r >= wy_r));
  assign cell_val = in_mask ? alu_sum[CNT_W-1:0] : '0;

  assign sts.skip      = dim_zero || bad_now;
  assign sts.walk_last = (i_r == r_last) && (j_r == c_last);
  assign sts.out_free  = !out_valid_r || out_tready;

  gpc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rows_r  <= rows_sat[DIM_W-1:0];
      cols_r  <= cols_sat[DIM_W-1:0];
      wzero_r <= (wp_in == '0);
      quo_r   <= wp_in - WP_W'(1);
      rem_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end
    if (ctl.div) begin
      // restoring divide: keep the trial difference when it does not borrow
      rem_r <= ge ? alu_sum[DIM_W-1:0] : shifted[DIM_W-1:0];
      quo_r <= {quo_r[WP_W-2:0], ge};
    end
    if (ctl.chk) begin
      bad_r <= bad_now;
      cnt_r <= '0;
      wx_r  <= wzero_r ? '0 : quo_r[IDX_W-1:0];
      wy_r  <= wzero_r ? '0 : rem_r[IDX_W-1:0];
    end
    if (ctl.walk) begin
      row_r[j_r] <= cell_val;
      left_r     <= cell_val;
      if (j_r == c_last) begin
        j_r <= '0;
        i_r <= i_r + IDX_W'(1);
      end else begin
        j_r <= j_r + IDX_W'(1);
      end
      if (sts.walk_last) cnt_r <= cell_val;
    end
  end

  // output register: load on handoff, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.res) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res) begin
      out_cnt_r <= cnt_r;
      out_bad_r <= bad_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_cnt_r);
  assign out_tuser  = out_bad_r;

endmodule

// ----- rtl/gpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpc_checker
// Port-level checks for the lattice path counter, bound to the top level.
// ----------------------------------------------------------------------------
module gpc_checker
  import gpc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a bad waypoint always reports a zero count
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("bad waypoint with nonzero count");

  // busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after an accepted item");

  // a new result only appears out of a busy cycle
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while idle");

endmodule

bind grid_path_count_via_waypoint gpc_checker u_gpc_checker (.*);
